/* design/hcb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hill cipher block package
// Shared widths, register indexes and modulo-26 helper functions.
// ----------------------------------------------------------------------------
package hcb_pkg;

    localparam int LETTER_W           = 5;
    localparam int KEY_W              = 15;
    localparam int KEY_DIM            = 3;
    localparam int CFG_INDEX_W        = 2;
    localparam int ACC_W              = 11;
    localparam int DEFAULT_BLOCK_SIZE = 3;
    // key register -> entries -> cofactors -> determinant -> inverse
    localparam int DERIVE_LAT         = 4;

    localparam logic [4:0]  MODULUS  = 5'd26;
    localparam logic [17:0] RECIP26  = 18'd78;   // floor(2048 / 26)
    localparam int          RECIP_SH = 11;

    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [KEY_W-1:0]    key_row_t;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_ROW_ZERO     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_ROW_ONE      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_ROW_TWO      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CIPHER_DIRECTION = 2'd3;

    localparam key_row_t KEY_ROW_ZERO_RST = 15'd1;
    localparam key_row_t KEY_ROW_ONE_RST  = 15'd32;
    localparam key_row_t KEY_ROW_TWO_RST  = 15'd1024;

    // Reduce 0..2047 mod 26: reciprocal estimate is low by at most one.
    function automatic letter_t red26(input logic [ACC_W-1:0] x);
        logic [17:0]      prod;
        logic [6:0]       quot;
        logic [ACC_W-1:0] rem;
        prod = 18'(x) * RECIP26;
        quot = prod[17:RECIP_SH];
        rem  = x - ACC_W'(quot) * ACC_W'(MODULUS);
        if (rem >= ACC_W'(MODULUS))
        begin
            rem = rem - ACC_W'(MODULUS);
        end
        return rem[LETTER_W-1:0];
    endfunction

    // Fold a 5-bit value into 0..25.
    function automatic letter_t fold26(input letter_t x);
        return (x >= MODULUS) ? letter_t'(x - MODULUS) : x;
    endfunction

    // (a - b) mod 26 for a, b in 0..25.
    function automatic letter_t sub26(input letter_t a, input letter_t b);
        logic [5:0] diff;
        if (a >= b)
        begin
            diff = 6'(a) - 6'(b);
        end
        else
        begin
            diff = 6'(a) + 6'(MODULUS) - 6'(b);
        end
        return diff[LETTER_W-1:0];
    endfunction

    // Multiplicative inverse mod 26; zero where none exists.
    function automatic letter_t inv26(input letter_t d);
        letter_t r;
        case (d)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

/* design/hill_cipher_block_mod26.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hill cipher block, modulo 26
// Gathers letters into blocks, multiplies each block by the key (or its
// inverse mod 26 in decrypt mode) and streams the transformed letters out.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_ready    letter_in, message_end
//  output    out_valid / out_ready  letter_out, block_last, key_not_invertible
//  config    cfg_write              cfg_index, cfg_data
//
//  One letter is taken per cycle while in_ready is high; a full block of
//  BLOCK_SIZE letters leaves as BLOCK_SIZE letters, one per cycle while
//  out_ready is high, so full blocks stream at one letter per cycle. A
//  short block closed by message_end still emits BLOCK_SIZE letters and
//  can hold the input off. Inverse key derivation is a 4-stage pipeline:
//  input is held off after reset and after each config write. Output
//  stalls back up through one block register into the gather stage.
// ----------------------------------------------------------------------------
module hill_cipher_block_mod26 #(
    parameter int BLOCK_SIZE = hcb_pkg::DEFAULT_BLOCK_SIZE
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [hcb_pkg::LETTER_W-1:0]    letter_in,
    input  logic                            message_end,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [hcb_pkg::LETTER_W-1:0]    letter_out,
    output logic                            block_last,
    output logic                            key_not_invertible,

    input  logic                            cfg_write,
    input  logic [hcb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hcb_pkg::KEY_W-1:0]       cfg_data
);

    localparam int HELD_W = (BLOCK_SIZE > 2) ? $clog2(BLOCK_SIZE) : 1;
    localparam int BUSY_W = $clog2(hcb_pkg::DERIVE_LAT + 1);
    localparam logic [HELD_W-1:0] LAST_POS = HELD_W'(BLOCK_SIZE - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    hcb_pkg::key_row_t key_reg [hcb_pkg::KEY_DIM];
    logic              dir_reg;
    logic [BUSY_W-1:0] busy_reg;
    logic [BUSY_W-1:0] busy_next;

    always_comb
    begin
        if (cfg_write)
        begin
            busy_next = BUSY_W'(hcb_pkg::DERIVE_LAT);
        end
        else if (busy_reg != '0)
        begin
            busy_next = busy_reg - 1'b1;
        end
        else
        begin
            busy_next = busy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0] <= hcb_pkg::KEY_ROW_ZERO_RST;
            key_reg[1] <= hcb_pkg::KEY_ROW_ONE_RST;
            key_reg[2] <= hcb_pkg::KEY_ROW_TWO_RST;
            dir_reg    <= 1'b0;
            busy_reg   <= BUSY_W'(hcb_pkg::DERIVE_LAT);
        end
        else
        begin
            busy_reg <= busy_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    hcb_pkg::REG_KEY_ROW_ZERO:     key_reg[0] <= cfg_data;
                    hcb_pkg::REG_KEY_ROW_ONE:      key_reg[1] <= cfg_data;
                    hcb_pkg::REG_KEY_ROW_TWO:      key_reg[2] <= cfg_data;
                    hcb_pkg::REG_CIPHER_DIRECTION: dir_reg    <= cfg_data[0];
                    default:                       ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Inverse key pipeline (free running from the key registers)
    // ------------------------------------------------------------------
    hcb_pkg::letter_t ent_reg [hcb_pkg::KEY_DIM][hcb_pkg::KEY_DIM];
    hcb_pkg::letter_t cof_next [hcb_pkg::KEY_DIM][hcb_pkg::KEY_DIM];
    hcb_pkg::letter_t cof_reg [hcb_pkg::KEY_DIM][hcb_pkg::KEY_DIM];
    hcb_pkg::letter_t det_reg;
    hcb_pkg::letter_t inv_reg [BLOCK_SIZE][BLOCK_SIZE];
    logic             inv_ok_reg;
    logic [hcb_pkg::ACC_W-1:0] det_sum;
    hcb_pkg::letter_t dinv;

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < hcb_pkg::KEY_DIM; r++)
        begin
            for (int c = 0; c < hcb_pkg::KEY_DIM; c++)
            begin
                ent_reg[r][c] <= hcb_pkg::fold26(key_reg[r][5*c +: 5]);
            end
        end
    end

    // Cofactors mod 26, sign already applied
    always_comb
    begin
        int r0, r1, c0, c1;
        hcb_pkg::letter_t p, q;
        r0 = 0;
        r1 = 0;
        c0 = 0;
        c1 = 0;
        p  = '0;
        q  = '0;
        for (int i = 0; i < hcb_pkg::KEY_DIM; i++)
        begin
            for (int j = 0; j < hcb_pkg::KEY_DIM; j++)
            begin
                cof_next[i][j] = '0;
            end
        end
        if (BLOCK_SIZE == 3)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    r0 = (i == 0) ? 1 : 0;
                    r1 = (i == 2) ? 1 : 2;
                    c0 = (j == 0) ? 1 : 0;
                    c1 = (j == 2) ? 1 : 2;
                    p  = hcb_pkg::red26(hcb_pkg::ACC_W'(ent_reg[r0][c0]) *
                                        hcb_pkg::ACC_W'(ent_reg[r1][c1]));
                    q  = hcb_pkg::red26(hcb_pkg::ACC_W'(ent_reg[r0][c1]) *
                                        hcb_pkg::ACC_W'(ent_reg[r1][c0]));
                    cof_next[i][j] = ((i + j) % 2 == 1) ? hcb_pkg::sub26(q, p)
                                                        : hcb_pkg::sub26(p, q);
                end
            end
        end
        else
        begin
            for (int i = 0; i < 2; i++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    cof_next[i][j] = ((i + j) % 2 == 1)
                                   ? hcb_pkg::sub26('0, ent_reg[1-i][1-j])
                                   : ent_reg[1-i][1-j];
                end
            end
        end
    end

    always_comb
    begin
        det_sum = '0;
        for (int j = 0; j < BLOCK_SIZE; j++)
        begin
            det_sum = det_sum + hcb_pkg::ACC_W'(ent_reg[0][j]) *
                                hcb_pkg::ACC_W'(cof_reg[0][j]);
        end
    end

    assign dinv = hcb_pkg::inv26(det_reg);

    always_ff @(posedge clk)
    begin
        cof_reg    <= cof_next;
        det_reg    <= hcb_pkg::red26(det_sum);
        inv_ok_reg <= (dinv != '0);
        for (int i = 0; i < BLOCK_SIZE; i++)
        begin
            for (int j = 0; j < BLOCK_SIZE; j++)
            begin
                // inverse = adjugate * det^-1, adjugate is the transposed cofactors
                inv_reg[i][j] <= hcb_pkg::red26(hcb_pkg::ACC_W'(cof_reg[j][i]) *
                                                 hcb_pkg::ACC_W'(dinv));
            end
        end
    end

    // ------------------------------------------------------------------
    // Gather stage and block register
    // ------------------------------------------------------------------
    hcb_pkg::letter_t buf_reg [BLOCK_SIZE];
    logic [HELD_W-1:0] held_reg;
    hcb_pkg::letter_t blk_reg [BLOCK_SIZE];
    hcb_pkg::letter_t blk_next [BLOCK_SIZE];
    logic              blk_valid_reg;
    hcb_pkg::letter_t letter_fold;
    logic              in_fire;
    logic              closes_block;
    logic              blk_move;
    logic              out_load_ok;

    hcb_pkg::letter_t res_reg [BLOCK_SIZE];
    hcb_pkg::letter_t res_next [BLOCK_SIZE];
    logic              bad_reg;
    logic              out_valid_reg;
    logic [HELD_W-1:0] idx_reg;
    logic              out_fire;

    assign letter_fold  = hcb_pkg::fold26(letter_in);
    assign closes_block = message_end || (held_reg == LAST_POS);
    assign out_fire     = out_valid_reg && out_ready;
    assign out_load_ok  = !out_valid_reg || (out_fire && idx_reg == LAST_POS);
    assign blk_move     = blk_valid_reg && out_load_ok;
    assign in_ready     = (busy_reg == '0) &&
                          (!blk_valid_reg || blk_move || !closes_block);
    assign in_fire      = in_valid && in_ready;

    // Slots past the current letter are still zero: that is the padding.
    always_comb
    begin
        for (int k = 0; k < BLOCK_SIZE; k++)
        begin
            blk_next[k] = buf_reg[k];
        end
        blk_next[held_reg] = letter_fold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            blk_valid_reg <= 1'b0;
            for (int k = 0; k < BLOCK_SIZE; k++)
            begin
                buf_reg[k] <= '0;
            end
        end
        else
        begin
            if (in_fire && closes_block)
            begin
                blk_valid_reg <= 1'b1;
                held_reg      <= '0;
                for (int k = 0; k < BLOCK_SIZE; k++)
                begin
                    buf_reg[k] <= '0;
                end
            end
            else
            begin
                if (blk_move)
                begin
                    blk_valid_reg <= 1'b0;
                end
                if (in_fire)
                begin
                    buf_reg[held_reg] <= letter_fold;
                    held_reg          <= held_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && closes_block)
        begin
            blk_reg <= blk_next;
        end
    end

    // ------------------------------------------------------------------
    // Matrix product and output register
    // ------------------------------------------------------------------
    logic bad_now;

    assign bad_now = dir_reg && !inv_ok_reg;

    always_comb
    begin
        logic [hcb_pkg::ACC_W-1:0] acc;
        hcb_pkg::letter_t          m;
        for (int i = 0; i < BLOCK_SIZE; i++)
        begin
            acc = '0;
            for (int k = 0; k < BLOCK_SIZE; k++)
            begin
                m   = dir_reg ? inv_reg[i][k] : ent_reg[i][k];
                acc = acc + hcb_pkg::ACC_W'(m) * hcb_pkg::ACC_W'(blk_reg[k]);
            end
            res_next[i] = bad_now ? '0 : hcb_pkg::red26(acc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (blk_move)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (out_fire)
            begin
                if (idx_reg == LAST_POS)
                begin
                    out_valid_reg <= 1'b0;
                    idx_reg       <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (blk_move)
        begin
            res_reg <= res_next;
            bad_reg <= bad_now;
        end
    end

    assign out_valid          = out_valid_reg;
    assign letter_out         = res_reg[idx_reg];
    assign block_last         = (idx_reg == LAST_POS);
    assign key_not_invertible = bad_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !in_ready)
        else $error("input taken while inverse key is being derived");

    a_bad_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_not_invertible |-> letter_out == '0)
        else $error("letter emitted with non-invertible key");

    a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> letter_out < hcb_pkg::MODULUS)
        else $error("output letter out of range");

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= LAST_POS)
        else $error("gather count past block size");

    a_block_close: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && closes_block |=> blk_valid_reg && held_reg == '0)
        else $error("closed block not moved to block register");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hill cipher block testbench
// Streams letters through the block under many key and direction settings
// and checks every emitted letter against an in-bench Hill cipher model.
// Both handshake sides idle at random, and one stretch holds the output off
// long enough for the block to fill and stall its input.
// ----------------------------------------------------------------------------
module testbench;

    localparam int BLOCK_SIZE    = hcb_pkg::DEFAULT_BLOCK_SIZE;
    localparam int ALPHABET      = hcb_pkg::MODULUS;
    localparam int SETTLE_CYCLES = hcb_pkg::DERIVE_LAT + 6;
    localparam int CYCLE_LIMIT   = 200000;

    localparam hcb_pkg::key_row_t DIR_ENCRYPT = 15'd0;
    localparam hcb_pkg::key_row_t DIR_DECRYPT = 15'd1;
    localparam logic [3:0] ALL_REGS       = 4'b1111;
    localparam logic [3:0] ONLY_DIRECTION = 4'b1000;
    localparam logic [hcb_pkg::CFG_INDEX_W-1:0] REG_ORDER [4] = '{
        hcb_pkg::REG_KEY_ROW_ZERO, hcb_pkg::REG_KEY_ROW_ONE,
        hcb_pkg::REG_KEY_ROW_TWO, hcb_pkg::REG_CIPHER_DIRECTION
    };

    typedef struct packed {
        hcb_pkg::letter_t text;
        logic             block_end;
        logic             no_inverse;
    } cipher_letter_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    hcb_pkg::letter_t   letter_in;
    logic               message_end;
    logic               out_valid;
    logic               out_ready;
    hcb_pkg::letter_t   letter_out;
    logic               block_last;
    logic               key_not_invertible;
    logic               cfg_write;
    logic [hcb_pkg::CFG_INDEX_W-1:0] cfg_index;
    hcb_pkg::key_row_t  cfg_data;

    // model state
    hcb_pkg::key_row_t key_rows [3];
    logic           decrypt_mode;
    int             gathered [3];
    int             gathered_count;
    int             decrypt_matrix [3][3];
    logic           decrypt_valid;
    cipher_letter_t expected_letters [$];

    int  errors          = 0;
    int  letters_offered = 0;
    int  letters_seen    = 0;
    int  letters_checked = 0;
    int  key_programs    = 0;
    int  decrypt_blocks  = 0;
    int  singular_blocks = 0;
    int  cycle_count     = 0;
    int  hold_request    = 0;
    bit  tx_gaps         = 1'b0;
    bit  rx_stalls       = 1'b0;

    hill_cipher_block_mod26 #(
        .BLOCK_SIZE(BLOCK_SIZE)
    ) u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .letter_in          (letter_in),
        .message_end        (message_end),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .letter_out         (letter_out),
        .block_last         (block_last),
        .key_not_invertible (key_not_invertible),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Cipher model
    // ------------------------------------------------------------------------
    function automatic int wrap26(input int v);
        int m;
        m = v % ALPHABET;
        return (m < 0) ? m + ALPHABET : m;
    endfunction

    function automatic int key_at(input int r, input int c);
        return int'(key_rows[r][5*c +: 5]) % ALPHABET;
    endfunction

    function automatic int minor_of(input int r, input int c);
        int rows [2];
        int cols [2];
        int n;
        int m;
        n = 0;
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (i != r)
            begin
                rows[n] = i;
                n++;
            end
            if (i != c)
            begin
                cols[m] = i;
                m++;
            end
        end
        return key_at(rows[0], cols[0]) * key_at(rows[1], cols[1])
             - key_at(rows[0], cols[1]) * key_at(rows[1], cols[0]);
    endfunction

    function automatic void rebuild_decrypt_matrix();
        int adj [3][3];
        int det;
        int det_inv;
        int t;
        det_inv = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                adj[i][j] = 0;
        if (BLOCK_SIZE == 2)
        begin
            det = key_at(0, 0) * key_at(1, 1) - key_at(0, 1) * key_at(1, 0);
            adj[0][0] = key_at(1, 1);
            adj[0][1] = -key_at(0, 1);
            adj[1][0] = -key_at(1, 0);
            adj[1][1] = key_at(0, 0);
        end
        else
        begin
            det = 0;
            for (int j = 0; j < 3; j++)
            begin
                t = key_at(0, j) * minor_of(0, j);
                det += (j % 2 == 1) ? -t : t;
            end
            // adjugate is the transposed cofactor matrix
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    t = minor_of(i, j);
                    adj[j][i] = ((i + j) % 2 == 1) ? -t : t;
                end
        end
        det = wrap26(det);
        for (int x = 1; x < ALPHABET; x++)
        begin
            if (det_inv == 0 && (det * x) % ALPHABET == 1)
            begin
                det_inv = x;
            end
        end
        decrypt_valid = (det_inv != 0);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                decrypt_matrix[i][j] = wrap26(wrap26(adj[i][j]) * det_inv);
    endfunction

    function automatic void reset_cipher_model();
        key_rows[0]    = hcb_pkg::KEY_ROW_ZERO_RST;
        key_rows[1]    = hcb_pkg::KEY_ROW_ONE_RST;
        key_rows[2]    = hcb_pkg::KEY_ROW_TWO_RST;
        decrypt_mode   = 1'b0;
        gathered_count = 0;
        for (int i = 0; i < 3; i++)
            gathered[i] = 0;
        rebuild_decrypt_matrix();
    endfunction

    function automatic void apply_register(input logic [hcb_pkg::CFG_INDEX_W-1:0] index,
                                           input hcb_pkg::key_row_t data);
        case (index)
            hcb_pkg::REG_KEY_ROW_ZERO:     key_rows[0] = data;
            hcb_pkg::REG_KEY_ROW_ONE:      key_rows[1] = data;
            hcb_pkg::REG_KEY_ROW_TWO:      key_rows[2] = data;
            hcb_pkg::REG_CIPHER_DIRECTION: decrypt_mode = data[0];
            default:                       return;
        endcase
        rebuild_decrypt_matrix();
    endfunction

    // Take one letter; on a full or closed block queue its transformed letters.
    function automatic void gather_letter(input hcb_pkg::letter_t raw, input logic closes);
        int   acc;
        int   coef;
        logic singular;
        if (gathered_count < BLOCK_SIZE)
        begin
            gathered[gathered_count] = int'(raw) % ALPHABET;
        end
        gathered_count++;
        if (gathered_count < BLOCK_SIZE && !closes)
        begin
            return;
        end
        singular = decrypt_mode && !decrypt_valid;
        for (int i = 0; i < BLOCK_SIZE; i++)
        begin
            acc = 0;
            for (int k = 0; k < BLOCK_SIZE; k++)
            begin
                coef = decrypt_mode ? decrypt_matrix[i][k] : key_at(i, k);
                acc += coef * gathered[k];
            end
            expected_letters.push_back(cipher_letter_t'{
                text:       singular ? hcb_pkg::letter_t'(0)
                                     : hcb_pkg::letter_t'(acc % ALPHABET),
                block_end:  (i == BLOCK_SIZE - 1),
                no_inverse: singular
            });
        end
        if (decrypt_mode)
        begin
            decrypt_blocks++;
        end
        if (singular)
        begin
            singular_blocks++;
        end
        gathered_count = 0;
        for (int i = 0; i < 3; i++)
            gathered[i] = 0;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: config writes, input and output transactions in one place
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string line);
        $display("mismatch: %s", line);
        errors++;
    endtask

    task automatic check_output();
        cipher_letter_t want;
        if (expected_letters.size() == 0)
        begin
            report_mismatch($sformatf("letter %0d arrived with nothing expected", letter_out));
            return;
        end
        want = expected_letters.pop_front();
        if (letter_out !== want.text)
        begin
            report_mismatch($sformatf("output %0d letter_out %0d, want %0d",
                                      letters_checked, letter_out, want.text));
        end
        if (block_last !== want.block_end)
        begin
            report_mismatch($sformatf("output %0d block_last %b, want %b",
                                      letters_checked, block_last, want.block_end));
        end
        if (key_not_invertible !== want.no_inverse)
        begin
            report_mismatch($sformatf("output %0d key_not_invertible %b, want %b",
                                      letters_checked, key_not_invertible, want.no_inverse));
        end
        letters_checked++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
            begin
                apply_register(cfg_index, cfg_data);
            end
            if (in_valid && in_ready)
            begin
                letters_seen++;
                gather_letter(letter_in, message_end);
            end
            if (out_valid && out_ready)
            begin
                check_output();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap(input bit enabled);
        int roll;
        if (!enabled)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic hcb_pkg::letter_t rand_letter();
        if ($urandom_range(0, 7) == 0)
        begin
            return hcb_pkg::letter_t'($urandom_range(26, 31));
        end
        return hcb_pkg::letter_t'($urandom_range(0, 25));
    endfunction

    function automatic hcb_pkg::key_row_t pack_row(input int e0, input int e1, input int e2);
        return {e2[4:0], e1[4:0], e0[4:0]};
    endfunction

    task automatic send_letter(input hcb_pkg::letter_t letter, input logic last_of_message);
        int gap;
        in_valid    <= 1'b1;
        letter_in   <= letter;
        message_end <= last_of_message;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        letters_offered++;
        gap = pick_gap(tx_gaps);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid, wait for every queued letter, then let the block settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_letters.size() != 0 || letters_seen != letters_offered)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input hcb_pkg::key_row_t row0, input hcb_pkg::key_row_t row1,
                                input hcb_pkg::key_row_t row2,
                                input hcb_pkg::key_row_t dir_word,
                                input logic [3:0] which);
        logic [3:0][hcb_pkg::KEY_W-1:0] words;
        words = {dir_word, row2, row1, row0};
        for (int i = 0; i < 4; i++)
        begin
            if (which[i])
            begin
                cfg_write <= 1'b1;
                cfg_index <= REG_ORDER[i];
                cfg_data  <= words[i];
                @(posedge clk);
            end
        end
        cfg_write <= 1'b0;
        key_programs++;
    endtask

    // Receiver: random stalls, or a long hold when a test asks for one.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (rx_stalls && $urandom_range(0, 2) == 0)
                begin
                    stall_left = pick_gap(1'b1);
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_identity_after_reset();
        wait_drained();
        // out-of-range letters fold mod 26; short blocks pad with zeros
        send_letter(5'd0, 1'b0);
        send_letter(5'd25, 1'b0);
        send_letter(5'd31, 1'b0);
        send_letter(5'd13, 1'b1);
        send_letter(5'd1, 1'b0);
        send_letter(5'd30, 1'b1);
    endtask

    task automatic test_encrypt_known_key();
        wait_drained();
        program_regs(pack_row(6, 24, 1), pack_row(13, 16, 10), pack_row(20, 17, 15),
                     DIR_ENCRYPT, ALL_REGS);
        send_letter(5'd0, 1'b0);
        send_letter(5'd2, 1'b0);
        send_letter(5'd19, 1'b0);
        send_letter(5'd7, 1'b1);
    endtask

    task automatic test_key_extremes();
        wait_drained();
        program_regs(15'h7FFF, 15'h7FFF, 15'h7FFF, DIR_ENCRYPT, ALL_REGS);
        send_letter(5'd25, 1'b0);
        send_letter(5'd25, 1'b0);
        send_letter(5'd25, 1'b0);
        wait_drained();
        program_regs(15'h0000, 15'h0000, 15'h0000, DIR_ENCRYPT, ALL_REGS);
        send_letter(5'd25, 1'b1);
    endtask

    task automatic test_decrypt_known_key();
        wait_drained();
        program_regs(pack_row(6, 24, 1), pack_row(13, 16, 10), pack_row(20, 17, 15),
                     DIR_DECRYPT, ALL_REGS);
        send_letter(5'd15, 1'b0);
        send_letter(5'd14, 1'b0);
        send_letter(5'd7, 1'b0);
    endtask

    task automatic test_singular_key();
        wait_drained();
        program_regs(pack_row(2, 0, 0), pack_row(0, 1, 0), pack_row(0, 0, 1),
                     DIR_DECRYPT, ALL_REGS);
        send_letter(5'd3, 1'b0);
        send_letter(5'd11, 1'b0);
        send_letter(5'd24, 1'b0);
    endtask

    // The direction in force when the block closes is the one that applies.
    task automatic test_direction_change_mid_block();
        wait_drained();
        program_regs(pack_row(6, 24, 1), pack_row(13, 16, 10), pack_row(20, 17, 15),
                     DIR_ENCRYPT, ALL_REGS);
        send_letter(5'd2, 1'b0);
        wait_drained();
        program_regs(15'h0000, 15'h0000, 15'h0000, DIR_DECRYPT, ONLY_DIRECTION);
        send_letter(5'd4, 1'b0);
        send_letter(5'd9, 1'b1);
    endtask

    task automatic test_output_backpressure();
        wait_drained();
        tx_gaps      = 1'b0;
        rx_stalls    = 1'b0;
        hold_request = 150;
        for (int n = 0; n < 36; n++)
            send_letter(rand_letter(), (n % 12) == 11);
    endtask

    task automatic test_random_traffic(input int phases, input int per_phase);
        int   msg_left;
        logic closes;
        for (int p = 0; p < phases; p++)
        begin
            wait_drained();
            program_regs(hcb_pkg::key_row_t'($urandom_range(0, 32767)),
                         hcb_pkg::key_row_t'($urandom_range(0, 32767)),
                         hcb_pkg::key_row_t'($urandom_range(0, 32767)),
                         hcb_pkg::key_row_t'($urandom_range(0, 32767)),
                         4'($urandom_range(1, 15)));
            // mix idle patterns: sender only, receiver only, both
            tx_gaps   = (p % 3) != 0;
            rx_stalls = (p % 3) != 1;
            msg_left  = 0;
            for (int n = 0; n < per_phase; n++)
            begin
                if (msg_left == 0)
                begin
                    msg_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                                            : $urandom_range(4, 20);
                end
                closes = (msg_left == 1) || (n == per_phase - 1)
                      || ($urandom_range(0, 29) == 0);
                send_letter(rand_letter(), closes);
                msg_left = closes ? 0 : msg_left - 1;
            end
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        letter_in   <= '0;
        message_end <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_index   <= hcb_pkg::REG_KEY_ROW_ZERO;
        cfg_data    <= '0;
        reset_cipher_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_identity_after_reset();
        test_encrypt_known_key();
        test_key_extremes();
        test_decrypt_known_key();
        test_singular_key();
        test_direction_change_mid_block();
        test_output_backpressure();
        test_random_traffic(11, 33);
        wait_drained();

        $display("run: %0d letters in, %0d letters out, %0d key programs",
                 letters_offered, letters_checked, key_programs);
        $display("run: %0d decrypt blocks, %0d with a singular key, %0d errors",
                 decrypt_blocks, singular_blocks, errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
design/hcb_pkg.sv
design/hill_cipher_block_mod26.sv
test/testbench.sv
